@@ rtl/drd_pkg.sv @@
// Package for the detection row decoder: widths, register indexes, record
// types and the frame and class-count clamping functions.
// Depends on nothing; every other file of the block uses it.
package drd_pkg;

   localparam int VALUE_BITS     = 16;
   localparam int FRAC_BITS      = 14;
   localparam int PIXEL_BITS     = 14;
   localparam int FRAME_BITS     = 13;
   localparam int CLASS_BITS     = 7;
   localparam int NUM_CLASSES    = 80;
   localparam int MAX_FRAME      = 4096;
   localparam int BOX_FIELDS     = 5;
   localparam int OBJ_POS        = 4;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_CONF_THRESHOLD = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH    = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT   = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CLASS_COUNT    = 8'd3;

   typedef struct packed {
      logic [VALUE_BITS-1:0] conf_threshold;
      logic [FRAME_BITS-1:0] frame_width;
      logic [FRAME_BITS-1:0] frame_height;
      logic [CLASS_BITS-1:0] class_count;
   } drd_cfg_type;

   // Everything gathered over one row, handed to the evaluation stage.
   typedef struct packed {
      logic [PIXEL_BITS-1:0] centre_x;
      logic [PIXEL_BITS-1:0] centre_y;
      logic [PIXEL_BITS-1:0] width;
      logic [PIXEL_BITS-1:0] height;
      logic [VALUE_BITS-1:0] objectness;
      logic [VALUE_BITS-1:0] best_score;
      logic [CLASS_BITS-1:0] best_class;
   } drd_row_type;

   typedef struct packed {
      logic [CLASS_BITS-1:0] class_index;
      logic [VALUE_BITS-1:0] confidence;
      logic [11:0]           box_x;
      logic [11:0]           box_y;
      logic [FRAME_BITS-1:0] box_width;
      logic [FRAME_BITS-1:0] box_height;
   } drd_result_type;

   function automatic logic [FRAME_BITS-1:0] eff_frame(input logic [FRAME_BITS-1:0] f);
      logic [FRAME_BITS-1:0] r;
      if (f == '0) begin
         r = FRAME_BITS'(1);
      end else if (f > FRAME_BITS'(MAX_FRAME)) begin
         r = FRAME_BITS'(MAX_FRAME);
      end else begin
         r = f;
      end
      return r;
   endfunction

   function automatic logic [CLASS_BITS-1:0] eff_classes(input logic [CLASS_BITS-1:0] c);
      logic [CLASS_BITS-1:0] r;
      if (c == '0) begin
         r = CLASS_BITS'(1);
      end else if (c > CLASS_BITS'(NUM_CLASSES)) begin
         r = CLASS_BITS'(NUM_CLASSES);
      end else begin
         r = c;
      end
      return r;
   endfunction

endpackage

@@ rtl/drd_req_if.sv @@
// Input channel of the detection row decoder: one row element per transfer.
// Depends on drd_pkg for the value width.
interface drd_req_if;
   logic                           valid;
   logic                           ready;
   logic [drd_pkg::VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

@@ rtl/drd_rsp_if.sv @@
// Result channel of the detection row decoder: one detection per transfer.
// Depends on drd_pkg for the field widths.
interface drd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [drd_pkg::CLASS_BITS-1:0] class_index;
   logic [drd_pkg::VALUE_BITS-1:0] confidence;
   logic [11:0]                    box_x;
   logic [11:0]                    box_y;
   logic [drd_pkg::FRAME_BITS-1:0] box_width;
   logic [drd_pkg::FRAME_BITS-1:0] box_height;

   modport source (output valid, output class_index, output confidence, output box_x,
                   output box_y, output box_width, output box_height, input ready);
   modport sink   (input valid, input class_index, input confidence, input box_x,
                   input box_y, input box_width, input box_height, output ready);
endinterface

@@ rtl/drd_csr_if.sv @@
// Configuration write channel of the detection row decoder.
// Depends on drd_pkg for the index and data widths.
interface drd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [drd_pkg::CSR_INDEX_BITS-1:0] index;
   logic [drd_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/drd_csr.sv @@
// Configuration registers of the detection row decoder.
// Depends on drd_pkg and drd_csr_if.
module drd_csr (
   input  logic                 clock,
   input  logic                 reset,
   drd_csr_if.sink              csr_bus,
   output drd_pkg::drd_cfg_type cfg
);

   drd_pkg::drd_cfg_type cfg_ff, cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            drd_pkg::REG_CONF_THRESHOLD: cfg_in.conf_threshold = csr_bus.data;
            drd_pkg::REG_FRAME_WIDTH:    cfg_in.frame_width = csr_bus.data[12:0];
            drd_pkg::REG_FRAME_HEIGHT:   cfg_in.frame_height = csr_bus.data[12:0];
            drd_pkg::REG_CLASS_COUNT:    cfg_in.class_count = csr_bus.data[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conf_threshold <= 16'd4096;
         cfg_ff.frame_width    <= 13'd640;
         cfg_ff.frame_height   <= 13'd480;
         cfg_ff.class_count    <= 7'd80;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/drd_row_collect.sv @@
// Row collection stage: scales box fields to pixels, runs the argmax over
// the class scores and registers the complete row at its last element.
// Depends on drd_pkg.
module drd_row_collect (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            take,
   input  logic [drd_pkg::VALUE_BITS-1:0]  value,
   input  drd_pkg::drd_cfg_type            cfg,
   output logic                            row_valid,
   output drd_pkg::drd_row_type            row
);

   logic [drd_pkg::CLASS_BITS-1:0] position_ff, position_in;
   logic [drd_pkg::PIXEL_BITS-1:0] centre_x_ff, centre_y_ff, width_ff, height_ff;
   logic [drd_pkg::VALUE_BITS-1:0] objectness_ff, best_score_ff, best_score_in;
   logic [drd_pkg::CLASS_BITS-1:0] best_class_ff, best_class_in;
   logic                           row_valid_ff, row_valid_in;
   drd_pkg::drd_row_type           row_ff;
   logic [drd_pkg::CLASS_BITS-1:0] classes;
   logic [drd_pkg::FRAME_BITS-1:0] scale;
   logic [28:0]                    product;
   logic [drd_pkg::PIXEL_BITS-1:0] pixels;
   logic                           in_box, last_score, score_wins;

   assign row_valid = row_valid_ff;
   assign row = row_ff;

   always_comb begin
      classes = drd_pkg::eff_classes(cfg.class_count);
      // Positions 0 and 2 are horizontal, 1 and 3 vertical.
      scale = position_ff[0] ? drd_pkg::eff_frame(cfg.frame_height)
                             : drd_pkg::eff_frame(cfg.frame_width);
      product = {13'd0, value} * {16'd0, scale};
      pixels = product[drd_pkg::FRAC_BITS +: drd_pkg::PIXEL_BITS];
      in_box = position_ff < drd_pkg::CLASS_BITS'(drd_pkg::BOX_FIELDS);
      score_wins = (position_ff == drd_pkg::CLASS_BITS'(drd_pkg::BOX_FIELDS))
                   || (value > best_score_ff);
      best_score_in = score_wins ? value : best_score_ff;
      best_class_in = score_wins
                      ? position_ff - drd_pkg::CLASS_BITS'(drd_pkg::BOX_FIELDS)
                      : best_class_ff;
      // A shrunken class count mid-row still ends the row on the next score.
      last_score = !in_box && (position_ff >= drd_pkg::CLASS_BITS'(drd_pkg::OBJ_POS) + classes);
      row_valid_in = take && last_score;
      position_in = position_ff;
      if (take) begin
         position_in = last_score ? '0 : position_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         row_valid_ff <= 1'b0;
      end else begin
         position_ff  <= position_in;
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         if (in_box) begin
            case (position_ff)
               7'd0:    centre_x_ff <= pixels;
               7'd1:    centre_y_ff <= pixels;
               7'd2:    width_ff <= pixels;
               7'd3:    height_ff <= pixels;
               default: objectness_ff <= value;
            endcase
         end else begin
            best_score_ff <= best_score_in;
            best_class_ff <= best_class_in;
         end
      end
      if (row_valid_in) begin
         row_ff.centre_x   <= centre_x_ff;
         row_ff.centre_y   <= centre_y_ff;
         row_ff.width      <= width_ff;
         row_ff.height     <= height_ff;
         row_ff.objectness <= objectness_ff;
         row_ff.best_score <= best_score_in;
         row_ff.best_class <= best_class_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_row_restarts: assert property (@(posedge clock) disable iff (reset)
      row_valid_ff |-> position_ff == '0 || position_ff == 7'd1)
      else $error("row record registered without the position returning to centre x");
   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      position_ff <= drd_pkg::CLASS_BITS'(drd_pkg::OBJ_POS + drd_pkg::NUM_CLASSES))
      else $error("element position ran past the longest row");
`endif

endmodule

@@ rtl/drd_row_eval.sv @@
// Row evaluation: confidence product, thresholds, corner box and clipping.
// Depends on drd_pkg.
module drd_row_eval (
   input  drd_pkg::drd_row_type    row,
   input  drd_pkg::drd_cfg_type    cfg,
   output logic                    keep,
   output drd_pkg::drd_result_type result
);

   logic [31:0]                    product;
   logic [31:0]                    thr_scaled;
   logic [drd_pkg::FRAME_BITS-1:0] fw, fh;
   logic signed [16:0]             x0, y0, x1, y1, x2, y2, fw_s, fh_s;
   logic                           pass_obj, pass_conf, empty;

   always_comb begin
      product = {16'd0, row.objectness} * {16'd0, row.best_score};
      thr_scaled = {2'd0, cfg.conf_threshold, 14'd0};
      pass_obj = row.objectness >= cfg.conf_threshold;
      pass_conf = product >= thr_scaled;
      fw = drd_pkg::eff_frame(cfg.frame_width);
      fh = drd_pkg::eff_frame(cfg.frame_height);
      fw_s = {4'd0, fw};
      fh_s = {4'd0, fh};
      x0 = {3'd0, row.centre_x} - {4'd0, row.width[13:1]};
      y0 = {3'd0, row.centre_y} - {4'd0, row.height[13:1]};
      x1 = x0[16] ? '0 : x0;
      y1 = y0[16] ? '0 : y0;
      x2 = x0 + {3'd0, row.width};
      y2 = y0 + {3'd0, row.height};
      if (x2 > fw_s) begin
         x2 = fw_s;
      end
      if (y2 > fh_s) begin
         y2 = fh_s;
      end
      empty = (x2 <= x1) || (y2 <= y1);
      keep = pass_obj && pass_conf && !empty;
      result.class_index = row.best_class;
      result.confidence = (product[31:30] != 2'd0) ? 16'hFFFF : product[29:14];
      result.box_x = x1[11:0];
      result.box_y = y1[11:0];
      result.box_width = 13'(x2 - x1);
      result.box_height = 13'(y2 - y1);
   end

endmodule

@@ rtl/drd_out_queue.sv @@
// Two-entry result queue in front of the result channel, so that the input
// side keeps moving while a detection waits. Depends on drd_pkg.
module drd_out_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  drd_pkg::drd_result_type push_data,
   output logic [1:0]              level,
   output logic                    out_valid,
   input  logic                    out_ready,
   output drd_pkg::drd_result_type out_data
);

   logic [1:0]              count_ff, count_in;
   drd_pkg::drd_result_type head_ff, spare_ff;
   logic                    pop;

   assign pop = (count_ff != 2'd0) && out_ready;
   assign level = count_ff;
   assign out_valid = count_ff != 2'd0;
   assign out_data = head_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         // The head leaves; the spare or the new entry moves up.
         if (count_ff == 2'd2) begin
            head_ff <= spare_ff;
            if (push) begin
               spare_ff <= push_data;
            end
         end else if (push) begin
            head_ff <= push_data;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_ff <= push_data;
         end else begin
            spare_ff <= push_data;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != 2'd2)
      else $error("result pushed into a full queue");
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 2'd1)
      else $error("queue level did not fall after a lone transfer out");
`endif

endmodule

@@ rtl/detection_row_decoder_unit.sv @@
// Detection row decoder. A detector output row streams in on req_bus one
// value per transfer: centre x, centre y, width, height, objectness, then
// class_count class scores, all unsigned Q2.14. Each accepted row yields at
// most one detection on rsp_bus: class, confidence and a clipped pixel box.
// Registers are to be written over csr_bus only while the block is idle; the
// block itself does not enforce this. csr_bus.ready is always high.
// Throughput: one value per cycle while req_bus.ready is high. The argmax
// and pixel scaling run on each value in the row collection stage; the last
// value of a row is registered, then evaluated (one 16x16 product, thresholds
// and clipping) into a two-entry result queue, from whose head a detection is
// offered on rsp_bus.
// When rsp_bus stalls, the queue holds up to two detections; req_bus.ready
// drops for a cycle only while one detection waits and another row is being
// evaluated, and stays low while the queue is full. Since a row is at least
// six values long this seldom costs input cycles.
// Reset (synchronous, active high) restores the register defaults, empties
// the queue and sets the row position back to centre x.
module detection_row_decoder_unit (
   input  logic      clock,
   input  logic      reset,
   drd_req_if.sink   req_bus,
   drd_rsp_if.source rsp_bus,
   drd_csr_if.sink   csr_bus
);

   drd_pkg::drd_cfg_type    cfg;
   drd_pkg::drd_row_type    row;
   drd_pkg::drd_result_type result, head;
   logic                    row_valid, keep, take;
   logic [1:0]              level;

   // Room is reserved for the row in evaluation as well as the queued ones.
   assign req_bus.ready = ({1'b0, level} + {2'd0, row_valid}) < 3'd2;
   assign take = req_bus.valid && req_bus.ready;

   drd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   drd_row_collect u_collect (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .value     (req_bus.value),
      .cfg       (cfg),
      .row_valid (row_valid),
      .row       (row)
   );

   drd_row_eval u_eval (
      .row    (row),
      .cfg    (cfg),
      .keep   (keep),
      .result (result)
   );

   drd_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (row_valid && keep),
      .push_data (result),
      .level     (level),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (head)
   );

   assign rsp_bus.class_index = head.class_index;
   assign rsp_bus.confidence  = head.confidence;
   assign rsp_bus.box_x       = head.box_x;
   assign rsp_bus.box_y       = head.box_y;
   assign rsp_bus.box_width   = head.box_width;
   assign rsp_bus.box_height  = head.box_height;

endmodule

@@ dv/tb_detection_row_decoder_unit.sv @@
// Self-checking testbench for detection_row_decoder_unit: streams detector rows,
// predicts each detection and compares it field by field on the result channel.
// Depends on drd_pkg and the drd_req_if, drd_rsp_if and drd_csr_if interfaces.
`timescale 1ns / 100ps

module tb_detection_row_decoder_unit;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASE_ITEMS    = 180;
   localparam int RANDOM_PHASES  = 9;

   logic clock = 1'b0;
   logic reset = 1'b1;

   drd_req_if req_bus();
   drd_rsp_if rsp_bus();
   drd_csr_if csr_bus();

   detection_row_decoder_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #10 clock = ~clock;

   // Register copy and row state of the decoder as the testbench sees them.
   logic [drd_pkg::VALUE_BITS-1:0] thr_reg;
   logic [drd_pkg::FRAME_BITS-1:0] fw_reg;
   logic [drd_pkg::FRAME_BITS-1:0] fh_reg;
   logic [drd_pkg::CLASS_BITS-1:0] cc_reg;
   int unsigned                    row_pos;
   longint unsigned                cx_px, cy_px, w_px, h_px;
   longint unsigned                obj_val, best_val;
   int unsigned                    best_idx;

   logic [drd_pkg::VALUE_BITS-1:0] pending_values[$];
   drd_pkg::drd_result_type        expected_detections[$];

   int send_idle_pct;
   int recv_idle_pct;
   int failures;
   int values_sent;
   int detections_checked;
   int reg_writes;
   int queued_count;
   int idle_cycles;

   function automatic longint unsigned clamp_frame(input logic [drd_pkg::FRAME_BITS-1:0] f);
      if (f == '0) return 1;
      if (f > drd_pkg::MAX_FRAME) return drd_pkg::MAX_FRAME;
      return f;
   endfunction

   function automatic int unsigned clamp_classes(input logic [drd_pkg::CLASS_BITS-1:0] c);
      if (c == '0) return 1;
      if (c > drd_pkg::NUM_CLASSES) return drd_pkg::NUM_CLASSES;
      return c;
   endfunction

   function automatic longint unsigned scale_px(input logic [drd_pkg::VALUE_BITS-1:0] v,
                                                input logic [drd_pkg::FRAME_BITS-1:0] f);
      longint unsigned pv;
      pv = v;
      return (pv * clamp_frame(f)) >> drd_pkg::FRAC_BITS;
   endfunction

   // Advances the row state by one element; returns 1 with the detection when
   // this element closes a row that survives the thresholds and clipping.
   function automatic bit decode_element(input logic [drd_pkg::VALUE_BITS-1:0] v,
                                         output drd_pkg::drd_result_type det);
      int unsigned     n;
      longint unsigned prod, conf, thr;
      longint          fw, fh, x0, y0, x1, y1, x2, y2;
      det = '0;
      n = clamp_classes(cc_reg);
      if (row_pos < drd_pkg::BOX_FIELDS) begin
         case (row_pos)
            0: cx_px = scale_px(v, fw_reg);
            1: cy_px = scale_px(v, fh_reg);
            2: w_px = scale_px(v, fw_reg);
            3: h_px = scale_px(v, fh_reg);
            default: obj_val = v;
         endcase
         row_pos++;
         return 0;
      end
      if (row_pos == drd_pkg::BOX_FIELDS || v > best_val) begin
         best_val = v;
         best_idx = row_pos - drd_pkg::BOX_FIELDS;
      end
      if (row_pos < drd_pkg::OBJ_POS + n) begin
         row_pos++;
         return 0;
      end
      row_pos = 0;
      thr = thr_reg;
      if (obj_val < thr) return 0;
      prod = obj_val * best_val;
      if (prod < (thr << drd_pkg::FRAC_BITS)) return 0;
      conf = prod >> drd_pkg::FRAC_BITS;
      if (conf > 65535) conf = 65535;
      fw = clamp_frame(fw_reg);
      fh = clamp_frame(fh_reg);
      x0 = longint'(cx_px) - longint'(w_px / 2);
      y0 = longint'(cy_px) - longint'(h_px / 2);
      x1 = (x0 < 0) ? 0 : x0;
      y1 = (y0 < 0) ? 0 : y0;
      x2 = x0 + longint'(w_px);
      y2 = y0 + longint'(h_px);
      if (x2 > fw) x2 = fw;
      if (y2 > fh) y2 = fh;
      if (x2 <= x1 || y2 <= y1) return 0;
      det.class_index = drd_pkg::CLASS_BITS'(best_idx);
      det.confidence  = drd_pkg::VALUE_BITS'(conf);
      det.box_x       = 12'(x1);
      det.box_y       = 12'(y1);
      det.box_width   = drd_pkg::FRAME_BITS'(x2 - x1);
      det.box_height  = drd_pkg::FRAME_BITS'(y2 - y1);
      return 1;
   endfunction

   // Input driver: offers the oldest pending value and predicts on each transfer.
   always @(posedge clock) begin : drive_req
      drd_pkg::drd_result_type det;
      bit                      fire;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         fire = req_bus.valid && req_bus.ready;
         if (fire) begin
            if (decode_element(req_bus.value, det)) begin
               expected_detections = {expected_detections, det};
            end
            void'(pending_values.pop_front());
            values_sent++;
         end
         if (!req_bus.valid || fire) begin
            if (pending_values.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_bus.valid <= 1'b1;
               req_bus.value <= pending_values[0];
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each transfer against the oldest predicted detection.
   always @(posedge clock) begin : watch_rsp
      drd_pkg::drd_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_detections.size() == 0) begin
               $error("unexpected detection: class_index %0d confidence %0d",
                      rsp_bus.class_index, rsp_bus.confidence);
               failures++;
            end else begin
               want = expected_detections.pop_front();
               if (rsp_bus.class_index !== want.class_index) begin
                  $error("class_index: expected %0d, actual %0d",
                         want.class_index, rsp_bus.class_index);
                  failures++;
               end
               if (rsp_bus.confidence !== want.confidence) begin
                  $error("confidence: expected %0d, actual %0d",
                         want.confidence, rsp_bus.confidence);
                  failures++;
               end
               if (rsp_bus.box_x !== want.box_x) begin
                  $error("box_x: expected %0d, actual %0d", want.box_x, rsp_bus.box_x);
                  failures++;
               end
               if (rsp_bus.box_y !== want.box_y) begin
                  $error("box_y: expected %0d, actual %0d", want.box_y, rsp_bus.box_y);
                  failures++;
               end
               if (rsp_bus.box_width !== want.box_width) begin
                  $error("box_width: expected %0d, actual %0d",
                         want.box_width, rsp_bus.box_width);
                  failures++;
               end
               if (rsp_bus.box_height !== want.box_height) begin
                  $error("box_height: expected %0d, actual %0d",
                         want.box_height, rsp_bus.box_height);
                  failures++;
               end
               detections_checked++;
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Ends the run if no channel completes a transfer for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_detection_row_decoder_unit failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [drd_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [drd_pkg::CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         drd_pkg::REG_CONF_THRESHOLD: thr_reg = val;
         drd_pkg::REG_FRAME_WIDTH:    fw_reg = val[drd_pkg::FRAME_BITS-1:0];
         drd_pkg::REG_FRAME_HEIGHT:   fh_reg = val[drd_pkg::FRAME_BITS-1:0];
         drd_pkg::REG_CLASS_COUNT:    cc_reg = val[drd_pkg::CLASS_BITS-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   // Waits until every value has gone in and every detection has come out,
   // then lets the evaluation stage run dry before any register changes.
   task automatic settle();
      while (pending_values.size() != 0 || req_bus.valid || expected_detections.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_value(input logic [drd_pkg::VALUE_BITS-1:0] v);
      pending_values = {pending_values, v};
      queued_count++;
   endtask

   // Queues one full row under the current class count. A clean row keeps the
   // box mostly inside the frame and the objectness at or above threshold.
   task automatic queue_row(input bit clean);
      int unsigned                    n;
      int                             k;
      logic [drd_pkg::VALUE_BITS-1:0] top, s;
      n = clamp_classes(cc_reg);
      if (!clean) begin
         repeat (drd_pkg::BOX_FIELDS + n) push_value(16'($urandom_range(0, 65535)));
      end else begin
         if ($urandom_range(0, 7) == 0) begin
            repeat (4) push_value(16'($urandom_range(0, 65535)));
         end else begin
            push_value(16'($urandom_range(0, 16'h4000)));
            push_value(16'($urandom_range(0, 16'h4000)));
            push_value(16'($urandom_range(16'h0040, 16'h3000)));
            push_value(16'($urandom_range(16'h0040, 16'h3000)));
         end
         push_value(16'($urandom_range(thr_reg, 16'hFFFF)));
         top = '0;
         for (k = 0; k < int'(n); k++) begin
            // Now and then repeat the best score so far to exercise ties.
            if (k > 0 && $urandom_range(0, 3) == 0) begin
               s = top;
            end else begin
               s = 16'($urandom_range(16'h2000, 16'hFFFF));
            end
            if (s > top) top = s;
            push_value(s);
         end
      end
   endtask

   initial begin : run
      logic [drd_pkg::VALUE_BITS-1:0]    directed_vals [0:27];
      logic [drd_pkg::CSR_DATA_BITS-1:0] t, fwv, fhv, ccv;
      int                                phase, pos_left;
      int unsigned                       n;

      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data  = '0;
      thr_reg = 16'd4096;
      fw_reg = 13'd640;
      fh_reg = 13'd480;
      cc_reg = 7'd80;
      row_pos = 0;
      cx_px = 0;
      cy_px = 0;
      w_px = 0;
      h_px = 0;
      obj_val = 0;
      best_val = 0;
      best_idx = 0;
      failures = 0;
      values_sent = 0;
      detections_checked = 0;
      reg_writes = 0;
      queued_count = 0;
      idle_cycles = 0;
      send_idle_pct = 20;
      recv_idle_pct = 64;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed rows, two classes, default threshold and frame: a tie on a
      // saturated score with a box larger than the frame, an empty box, an
      // objectness just under threshold, and an objectness exactly at
      // threshold whose product falls just short.
      write_reg(drd_pkg::REG_CLASS_COUNT, 16'd2);
      directed_vals = '{16'h2000, 16'h2000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000,
                        16'h2000, 16'h2000, 16'h1000, 16'h1000, 16'h0FFF, 16'h8000, 16'h8000,
                        16'hFFFF, 16'hFFFF, 16'h4000, 16'h4000, 16'h1000, 16'h3FFF, 16'h0FFF};
      @(negedge clock);
      foreach (directed_vals[i]) push_value(directed_vals[i]);
      settle();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 3) begin
            send_idle_pct = 64;
            recv_idle_pct = 20;
         end else if (phase == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            0: begin
               t = 16'h0000;
               fwv = 16'h0000;
               fhv = 16'hFFFF;
               ccv = 16'h0000;
            end
            1: begin
               t = 16'hFFFF;
               fwv = 16'd4096;
               fhv = 16'd4096;
               ccv = 16'd127;
            end
            2: begin
               t = 16'h0001;
               fwv = 16'd4097;
               fhv = 16'd1;
               ccv = 16'd80;
            end
            default: begin
               case ($urandom_range(0, 9))
                  0: t = 16'h0000;
                  1: t = 16'hFFFF;
                  default: t = 16'($urandom_range(0, 16'h3000));
               endcase
               fwv = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(1, drd_pkg::MAX_FRAME));
               fhv = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(1, drd_pkg::MAX_FRAME));
               ccv = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(9, 20))
                                                 : 16'($urandom_range(1, 8));
               // Spare bits above each register's width must be dropped.
               ccv[15:7] = 9'($urandom_range(0, 511));
            end
         endcase
         write_reg(drd_pkg::REG_CONF_THRESHOLD, t);
         write_reg(drd_pkg::REG_FRAME_WIDTH, fwv);
         write_reg(drd_pkg::REG_FRAME_HEIGHT, fhv);
         write_reg(drd_pkg::REG_CLASS_COUNT, ccv);
         if ($urandom_range(0, 2) == 0) begin
            write_reg(8'($urandom_range(4, 255)), 16'($urandom_range(0, 65535)));
         end

         @(negedge clock);
         queued_count = 0;
         // A row left open by the previous phase is finished under the new
         // class count, which may already lie behind its position.
         n = clamp_classes(cc_reg);
         if (row_pos != 0) begin
            if (row_pos < drd_pkg::BOX_FIELDS) begin
               pos_left = drd_pkg::BOX_FIELDS + n - row_pos;
            end else if (row_pos >= drd_pkg::OBJ_POS + n) begin
               pos_left = 1;
            end else begin
               pos_left = drd_pkg::OBJ_POS + n - row_pos + 1;
            end
            repeat (pos_left) push_value(16'($urandom_range(0, 65535)));
         end
         while (queued_count < PHASE_ITEMS) queue_row($urandom_range(0, 9) < 8);
         if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, drd_pkg::OBJ_POS + n))
               push_value(16'($urandom_range(0, 65535)));
         end
         settle();
      end

      $display("Sent %0d row values over %0d register writes; %0d detections checked.",
               values_sent, reg_writes, detections_checked);
      $display("Settings spanned threshold and frame extremes, clamped class counts and "
               , "rows reshaped mid-flight.");
      if (failures == 0) begin
         $display("tb_detection_row_decoder_unit passed");
      end else begin
         $display("tb_detection_row_decoder_unit failed");
      end
      $finish;
   end

endmodule
